// ----- hw/rtl/brs_pkg.sv -----
// shared types and constants of the bounded record stack
`default_nettype none

package brs_pkg;

    // stored record, one per cell
    typedef struct packed {
        logic [15:0] proc;
        logic [15:0] gpu;
        logic [9:0]  ram;
        logic [7:0]  disk;
        logic [9:0]  screen;
    } rec_t;

    typedef enum logic [2:0] {
        OP_PUSH   = 3'd0,
        OP_POP    = 3'd1,
        OP_PEEK   = 3'd2,
        OP_SEARCH = 3'd3,
        OP_CLEAR  = 3'd4,
        OP_SIZE   = 3'd5,
        OP_DUMP   = 3'd6,
        OP_NOP    = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOTFOUND = 2'd3
    } stat_t;

    // what every cell loads in a cycle
    typedef enum logic [1:0] {
        CELL_HOLD      = 2'd0,
        CELL_TAKE_PREV = 2'd1,
        CELL_TAKE_NEXT = 2'd2
    } cell_cmd_t;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_EXEC   = 2'd1,
        S_WALK   = 2'd2,
        S_FINISH = 2'd3
    } fsm_t;

    localparam logic [3:0] CAP_RESET = 4'd5;

endpackage

`default_nettype wire

// ----- hw/rtl/brs_cell.sv -----
// one storage cell of the record chain
`default_nettype none

module brs_cell
    import brs_pkg::*;
(
    input  wire       clk,
    input  cell_cmd_t cmd,
    input  rec_t      prev_rec,
    input  rec_t      next_rec,
    output rec_t      rec
);

    rec_t rec_reg;
    rec_t rec_next;

    always_comb
    begin
        case (cmd)
            CELL_TAKE_PREV: rec_next = prev_rec;
            CELL_TAKE_NEXT: rec_next = next_rec;
            default:        rec_next = rec_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

    assign rec = rec_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/bounded_record_stack.sv -----
// top level of the bounded record stack: cell chain, sequencer and output register
`default_nettype none

// bounded LIFO of hardware records held in a row of DEPTH cells, top of stack in cell 0
// input stream: one transfer per operation (push, pop, peek, search, clear, size, dump)
// output stream: one transfer per result; search gives one per match, dump one per record,
//   tlast on the final result of an operation, a single status transfer when nothing is emitted
// cfg_we/cfg_wdata write the capacity limit; write only while the block is idle
// a simple operation is executed in the execute state after its input transfer, once the
//   output register is free, and its result is registered there, which raises output tvalid
// only one operation is handled at a time, the input waits until the sequencer is idle;
//   search and dump rotate the whole cell ring once, one cell per cycle unless the output stalls
// push shifts the chain toward the bottom, pop shifts it toward the top; a walk rotates the
//   ring a full turn so the chain ends where it started
// reset: stack empty, capacity limit 5, output idle; the cells themselves are not cleared
// receiver stall: the output register holds its transfer, the sequencer and the cell chain
//   freeze whenever they would need to emit, and no item is lost

module bounded_record_stack
    import brs_pkg::*;
#(
    parameter int DEPTH = 8
)
(
    input  wire         clk,
    input  wire         rst_n,
    // op[2:0], processor_id[18:3], gpu_id[34:19], ram_gb[44:35], disk_tb[52:45],
    // screen_tenths[62:53], zero [63]
    input  wire  [63:0] s_axis_tdata,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // count[3:0], out_processor[19:4], out_gpu[35:20], out_ram[45:36], out_disk[53:46],
    // out_screen[63:54]
    output logic [63:0] m_axis_tdata,
    // status[1:0], has_entry[2]
    output logic [2:0]  m_axis_tuser,
    output logic        m_axis_tlast,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    input  wire         cfg_we,
    input  wire  [3:0]  cfg_wdata
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int KW   = $clog2(DEPTH);
    localparam int CMPW = (CW > 4) ? CW : 4;

    // control state
    fsm_t            state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [KW-1:0]   k_reg, k_next;
    logic            pend_valid_reg, pend_valid_next;
    logic [3:0]      cap_reg;

    // command and pending search hit
    op_t             op_reg;
    logic [15:0]     key_reg;
    rec_t            rec_in_reg;
    rec_t            pend_rec_reg, pend_rec_next;

    // output register
    logic            m_valid_reg;
    stat_t           m_status_reg;
    logic [3:0]      m_count_reg;
    logic            m_has_reg;
    rec_t            m_rec_reg;
    logic            m_last_reg;

    // emission from the sequencer
    logic            emit;
    stat_t           e_status;
    logic            e_has;
    rec_t            e_rec;
    logic            e_last;

    // cell chain
    rec_t            cell_q [DEPTH];
    rec_t            cell0_prev;
    cell_cmd_t       cell_cmd;

    logic            s_accept;
    logic            slot_free;
    logic [CMPW-1:0] cap_ext;
    logic [CMPW-1:0] eff_cap;
    logic            is_full;
    logic [CW-1:0]   search_idx;
    logic            search_hit;
    logic            dump_in_range;
    logic            step_ok;

    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign slot_free     = !m_valid_reg || m_axis_tready;

    // capacity clamped to 1..DEPTH
    assign cap_ext = CMPW'(cap_reg);
    always_comb
    begin
        if (cap_ext == '0)
            eff_cap = CMPW'(1);
        else if (cap_ext > CMPW'(DEPTH))
            eff_cap = CMPW'(DEPTH);
        else
            eff_cap = cap_ext;
    end
    assign is_full = (CMPW'(count_reg) >= eff_cap);

    // push feeds cell 0 from the command, a reverse rotation wraps the last cell around
    assign cell0_prev = (state_reg == S_EXEC) ? rec_in_reg : cell_q[DEPTH-1];

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            localparam int NXT = (gi + 1) % DEPTH;
            brs_cell u_cell (
                .clk      (clk),
                .cmd      (cell_cmd),
                .prev_rec ((gi == 0) ? cell0_prev : cell_q[(gi == 0) ? 0 : gi - 1]),
                .next_rec (cell_q[NXT]),
                .rec      (cell_q[gi])
            );
        end
    endgenerate

    // search walks the reverse ring and watches the last cell: original positions
    // DEPTH-1 down to 0, i.e. bottom of stack first
    assign search_idx    = CW'(DEPTH - 1) - CW'(k_reg);
    assign search_hit    = (search_idx < count_reg) && (cell_q[DEPTH-1].proc == key_reg);
    // dump walks the forward ring and watches cell 0: top of stack first
    assign dump_in_range = (CW'(k_reg) < count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            k_reg          <= '0;
            pend_valid_reg <= 1'b0;
            cap_reg        <= CAP_RESET;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            k_reg          <= k_next;
            pend_valid_reg <= pend_valid_next;
            if (cfg_we)
                cap_reg <= cfg_wdata;
            if (emit)
                m_valid_reg <= 1'b1;
            else if (m_axis_tready)
                m_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            op_reg     <= op_t'(s_axis_tdata[2:0]);
            key_reg    <= s_axis_tdata[18:3];
            rec_in_reg <= '{proc:   s_axis_tdata[18:3],
                            gpu:    s_axis_tdata[34:19],
                            ram:    s_axis_tdata[44:35],
                            disk:   s_axis_tdata[52:45],
                            screen: s_axis_tdata[62:53]};
        end
        pend_rec_reg <= pend_rec_next;
        if (emit)
        begin
            m_status_reg <= e_status;
            m_count_reg  <= 4'(count_next);
            m_has_reg    <= e_has;
            m_rec_reg    <= e_rec;
            m_last_reg   <= e_last;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        k_next          = k_reg;
        pend_valid_next = pend_valid_reg;
        pend_rec_next   = pend_rec_reg;
        cell_cmd        = CELL_HOLD;
        emit            = 1'b0;
        e_status        = ST_OK;
        e_has           = 1'b0;
        e_rec           = '0;
        e_last          = 1'b1;
        step_ok         = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_accept)
                    state_next = S_EXEC;
            end

            S_EXEC:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                    if (op_reg != OP_PUSH && op_reg != OP_NOP && count_reg == '0)
                    begin
                        emit     = 1'b1;
                        e_status = ST_EMPTY;
                    end
                    else
                    begin
                        unique case (op_reg)
                            OP_PUSH:
                            begin
                                emit = 1'b1;
                                if (is_full)
                                    e_status = ST_FULL;
                                else
                                begin
                                    cell_cmd   = CELL_TAKE_PREV;
                                    count_next = count_reg + CW'(1);
                                    e_has      = 1'b1;
                                    e_rec      = rec_in_reg;
                                end
                            end
                            OP_POP:
                            begin
                                emit       = 1'b1;
                                cell_cmd   = CELL_TAKE_NEXT;
                                count_next = count_reg - CW'(1);
                                e_has      = 1'b1;
                                e_rec      = cell_q[0];
                            end
                            OP_PEEK:
                            begin
                                emit  = 1'b1;
                                e_has = 1'b1;
                                e_rec = cell_q[0];
                            end
                            OP_SEARCH, OP_DUMP:
                            begin
                                k_next          = '0;
                                pend_valid_next = 1'b0;
                                state_next      = S_WALK;
                            end
                            OP_CLEAR:
                            begin
                                emit       = 1'b1;
                                count_next = '0;
                            end
                            default:
                            begin
                                // size and the unused code just report the count
                                emit = 1'b1;
                            end
                        endcase
                    end
                end
            end

            S_WALK:
            begin
                if (op_reg == OP_SEARCH)
                begin
                    // a new hit pushes the held one out, which is then known not to be last
                    step_ok = !(search_hit && pend_valid_reg) || slot_free;
                    if (step_ok)
                    begin
                        cell_cmd = CELL_TAKE_PREV;
                        if (search_hit)
                        begin
                            if (pend_valid_reg)
                            begin
                                emit   = 1'b1;
                                e_has  = 1'b1;
                                e_rec  = pend_rec_reg;
                                e_last = 1'b0;
                            end
                            pend_valid_next = 1'b1;
                            pend_rec_next   = cell_q[DEPTH-1];
                        end
                    end
                end
                else
                begin
                    step_ok = !dump_in_range || slot_free;
                    if (step_ok)
                    begin
                        cell_cmd = CELL_TAKE_NEXT;
                        if (dump_in_range)
                        begin
                            emit   = 1'b1;
                            e_has  = 1'b1;
                            e_rec  = cell_q[0];
                            e_last = (CW'(k_reg) + CW'(1) == count_reg);
                        end
                    end
                end
                if (step_ok)
                begin
                    k_next = k_reg + KW'(1);
                    if (k_reg == KW'(DEPTH - 1))
                        state_next = (op_reg == OP_SEARCH) ? S_FINISH : S_IDLE;
                end
            end

            S_FINISH:
            begin
                if (slot_free)
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                    if (pend_valid_reg)
                    begin
                        e_has = 1'b1;
                        e_rec = pend_rec_reg;
                    end
                    else
                        e_status = ST_NOTFOUND;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tuser  = {m_has_reg, m_status_reg};
    assign m_axis_tdata  = {m_rec_reg.screen, m_rec_reg.disk, m_rec_reg.ram,
                            m_rec_reg.gpu, m_rec_reg.proc, m_count_reg};

    // the stack never holds more than the cells can
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("stack count beyond depth");

    // the count only moves when a command is carried out
    a_count_only_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_EXEC) |=> (count_reg == $past(count_reg)))
        else $error("stack count changed outside command execution");

    // an accepted item always takes the sequencer into its execute state
    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept |=> (state_reg == S_EXEC))
        else $error("accepted item not executed");

    // results without a record carry zero record fields
    a_no_entry_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[2]) |-> (m_axis_tdata[63:4] == '0))
        else $error("record fields set on a status-only result");

    // failed results are always the final transfer and carry no record
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser[1:0] != ST_OK)) |-> (m_axis_tlast && !m_axis_tuser[2]))
        else $error("error status result not final or carries a record");

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
// self-checking testbench of the bounded record stack: stream driver, result monitor, predictor
`timescale 1ns / 1ps

module testbench;
    import brs_pkg::*;

    localparam int STACK_DEPTH    = 8;
    // receiver hold-off, long enough for the output register and the sequencer to back up
    localparam int HOLDOFF_CYCLES = 150;
    // no transfer at all for this long means the block is hung
    localparam int QUIET_LIMIT    = 2000;
    // spare time after the run so that a stray trailing result still shows up
    localparam int DRAIN_CYCLES   = 24;

    // one operation as it goes into the block
    typedef struct packed {
        op_t  op;
        rec_t rec;      // rec.proc doubles as the search key
    } stack_op_s;

    // one result as it comes out of the block
    typedef struct packed {
        stat_t       status;
        logic [3:0]  count;
        logic        has_entry;
        rec_t        rec;
        logic        last;
    } stack_result_s;

    // block ports, every input known from time zero
    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic [63:0] s_axis_tdata  = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic        cfg_we        = 1'b0;
    logic [3:0]  cfg_wdata     = '0;

    // operations waiting to be sent, and results still owed by the block
    stack_op_s     op_backlog[$];
    stack_result_s result_due[$];

    // shadow copy of the stack: cell 0 is the bottom here
    rec_t        model_cells [STACK_DEPTH];
    int unsigned model_used     = 0;
    logic [3:0]  model_capacity = CAP_RESET;

    // driver state
    stack_op_s   on_offer;
    bit          offering = 1'b0;

    // monitor state
    stack_result_s seen;
    stack_result_s want;
    int            holdoff_left   = 0;
    int            stall_requests = 0;
    int            stall_served   = 0;

    // shared run state
    bit          calm = 1'b0;       // no random idling on either side
    logic [15:0] key_pool [3];
    int          mismatches   = 0;
    int          quiet_cycles = 0;

    bounded_record_stack #(
        .DEPTH (STACK_DEPTH)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // count field always reflects the depth after the operation
    task automatic owe_result(input stat_t status, input logic has_entry, input rec_t rec,
                              input logic last);
        stack_result_s r;
        r.status    = status;
        r.count     = model_used[3:0];
        r.has_entry = has_entry;
        r.rec       = has_entry ? rec : '0;
        r.last      = last;
        result_due.push_back(r);
    endtask

    task automatic predict_stack_results(input stack_op_s item);
        int unsigned cap;
        int          hits;
        int          k;
        // a capacity of zero behaves as one, anything past the depth as the depth
        cap = (model_capacity == 4'd0) ? 1 : int'(model_capacity);
        if (cap > STACK_DEPTH)
            cap = STACK_DEPTH;
        if (item.op != OP_PUSH && item.op != OP_NOP && model_used == 0)
        begin
            // anything but push or the spare opcode on an empty stack
            owe_result(ST_EMPTY, 1'b0, '0, 1'b1);
        end
        else
        begin
            case (item.op)
                OP_PUSH:
                begin
                    // also full when the limit was lowered under the current depth
                    if (model_used >= cap)
                        owe_result(ST_FULL, 1'b0, '0, 1'b1);
                    else
                    begin
                        model_cells[model_used] = item.rec;
                        model_used++;
                        owe_result(ST_OK, 1'b1, item.rec, 1'b1);
                    end
                end
                OP_POP:
                begin
                    model_used--;
                    owe_result(ST_OK, 1'b1, model_cells[model_used], 1'b1);
                end
                OP_PEEK:
                    owe_result(ST_OK, 1'b1, model_cells[model_used - 1], 1'b1);
                OP_SEARCH:
                begin
                    // bottom to top, tlast on the final match
                    hits = 0;
                    for (k = 0; k < int'(model_used); k++)
                        if (model_cells[k].proc == item.rec.proc)
                            hits++;
                    if (hits == 0)
                        owe_result(ST_NOTFOUND, 1'b0, '0, 1'b1);
                    else
                    begin
                        for (k = 0; k < int'(model_used); k++)
                        begin
                            if (model_cells[k].proc == item.rec.proc)
                            begin
                                hits--;
                                owe_result(ST_OK, 1'b1, model_cells[k], hits == 0);
                            end
                        end
                    end
                end
                OP_CLEAR:
                begin
                    model_used = 0;
                    owe_result(ST_OK, 1'b0, '0, 1'b1);
                end
                OP_DUMP:
                begin
                    // top to bottom, tlast on the bottom record
                    for (k = int'(model_used) - 1; k >= 0; k--)
                        owe_result(ST_OK, 1'b1, model_cells[k], k == 0);
                end
                default:
                    // size and the spare opcode only report the depth
                    owe_result(ST_OK, 1'b0, '0, 1'b1);
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic stack_op_s make_op(input op_t op, input logic [15:0] proc,
                                          input logic [15:0] gpu, input logic [9:0] ram,
                                          input logic [7:0] disk, input logic [9:0] screen);
        stack_op_s s;
        s.op         = op;
        s.rec.proc   = proc;
        s.rec.gpu    = gpu;
        s.rec.ram    = ram;
        s.rec.disk   = disk;
        s.rec.screen = screen;
        return s;
    endfunction

    // mostly keys from the pool so that searches find several records
    function automatic logic [15:0] pick_key();
        if ($urandom_range(0, 99) < 80)
            return key_pool[$urandom_range(0, 2)];
        return 16'($urandom_range(0, 65535));
    endfunction

    // push-heavy mix so the stack spends most of its time well filled
    task automatic queue_random_ops(input int n, input bit pushes_only);
        int   i;
        int   roll;
        op_t  op;
        for (i = 0; i < n; i++)
        begin
            roll = pushes_only ? 0 : $urandom_range(0, 99);
            if (roll < 40)      op = OP_PUSH;
            else if (roll < 52) op = OP_POP;
            else if (roll < 60) op = OP_PEEK;
            else if (roll < 74) op = OP_SEARCH;
            else if (roll < 77) op = OP_CLEAR;
            else if (roll < 82) op = OP_SIZE;
            else if (roll < 94) op = OP_DUMP;
            else                op = OP_NOP;
            op_backlog.push_back(make_op(op, pick_key(), 16'($urandom_range(0, 65535)),
                                         10'($urandom_range(0, 1023)),
                                         8'($urandom_range(0, 255)),
                                         10'($urandom_range(0, 1023))));
        end
    endtask

    // sender pauses here until the block owes nothing
    task automatic wait_idle();
        while (op_backlog.size() != 0 || offering || result_due.size() != 0)
            @(posedge clk);
    endtask

    // register write, only ever issued once the bench owes nothing
    task automatic write_capacity(input logic [3:0] value);
        @(posedge clk);
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
        model_capacity = value;
    endtask

    task automatic run_phase(input logic [3:0] cap, input int n, input bit quiet,
                             input bit holdoff, input bit pushes_only);
        write_capacity(cap);
        calm        = quiet;
        key_pool[0] = 16'($urandom_range(0, 65535));
        key_pool[1] = 16'($urandom_range(0, 65535));
        key_pool[2] = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        if (holdoff)
            stall_requests++;
        queue_random_ops(n, pushes_only);
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // driver: one item on offer at a time, held until its transfer
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_stack_results(on_offer);
                offering = 1'b0;
            end
            if (!offering && op_backlog.size() != 0 && (calm || $urandom_range(0, 99) >= 32))
            begin
                on_offer = op_backlog.pop_front();
                offering = 1'b1;
                // op, processor, gpu, ram, disk, screen from bit 0 up, top bit zero
                s_axis_tdata <= {1'b0, on_offer.rec.screen, on_offer.rec.disk,
                                 on_offer.rec.ram, on_offer.rec.gpu, on_offer.rec.proc,
                                 on_offer.op};
            end
            s_axis_tvalid <= offering;
        end
    end

    // ------------------------------------------------------------------
    // monitor: checks each result transfer and drives tready
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input int unsigned exp_val,
                               input int unsigned act_val);
        if (exp_val != act_val)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen.status    = stat_t'(m_axis_tuser[1:0]);
                seen.has_entry = m_axis_tuser[2];
                seen.count     = m_axis_tdata[3:0];
                seen.rec       = {m_axis_tdata[19:4], m_axis_tdata[35:20], m_axis_tdata[45:36],
                                  m_axis_tdata[53:46], m_axis_tdata[63:54]};
                seen.last      = m_axis_tlast;
                if (result_due.size() == 0)
                begin
                    $error("result transfer with none expected: tdata %h tuser %h",
                           m_axis_tdata, m_axis_tuser);
                    mismatches++;
                end
                else
                begin
                    want = result_due.pop_front();
                    check_field("status", want.status, seen.status);
                    check_field("count", want.count, seen.count);
                    check_field("has_entry", want.has_entry, seen.has_entry);
                    check_field("out_processor", want.rec.proc, seen.rec.proc);
                    check_field("out_gpu", want.rec.gpu, seen.rec.gpu);
                    check_field("out_ram", want.rec.ram, seen.rec.ram);
                    check_field("out_disk", want.rec.disk, seen.rec.disk);
                    check_field("out_screen", want.rec.screen, seen.rec.screen);
                    check_field("last", want.last, seen.last);
                end
            end
            // a long hold-off while the driver keeps offering, so the input backs up
            if (stall_requests != stall_served)
            begin
                stall_served = stall_requests;
                holdoff_left = HOLDOFF_CYCLES;
            end
            if (holdoff_left > 0)
            begin
                holdoff_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= calm || ($urandom_range(0, 99) >= 32);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // sequence of the run
    // ------------------------------------------------------------------
    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed part at the reset capacity of five
        // every read op on an empty stack, and the spare opcode there
        op_backlog.push_back(make_op(OP_POP,    16'h0000, '0, '0, '0, '0));
        op_backlog.push_back(make_op(OP_PEEK,   16'h0000, '0, '0, '0, '0));
        op_backlog.push_back(make_op(OP_SEARCH, 16'h0000, '0, '0, '0, '0));
        op_backlog.push_back(make_op(OP_CLEAR,  16'h0000, '0, '0, '0, '0));
        op_backlog.push_back(make_op(OP_SIZE,   16'h0000, '0, '0, '0, '0));
        op_backlog.push_back(make_op(OP_DUMP,   16'h0000, '0, '0, '0, '0));
        op_backlog.push_back(make_op(OP_NOP,    16'hFFFF, '1, '1, '1, '1));
        // field extremes, duplicate keys, then one push past the limit
        op_backlog.push_back(make_op(OP_PUSH, 16'h0000, 16'h0000, 10'd0, 8'd0, 10'd0));
        op_backlog.push_back(make_op(OP_PUSH, 16'hFFFF, 16'hFFFF, 10'd1023, 8'd255, 10'd1023));
        op_backlog.push_back(make_op(OP_PUSH, 16'h0000, 16'h5A5A, 10'd512, 8'd128, 10'd155));
        op_backlog.push_back(make_op(OP_PUSH, 16'h1234, 16'hA5A5, 10'd1, 8'd1, 10'd1));
        op_backlog.push_back(make_op(OP_PUSH, 16'hFFFF, 16'h0000, 10'h2AA, 8'h55, 10'h155));
        op_backlog.push_back(make_op(OP_PUSH, 16'h7777, 16'h8888, 10'd300, 8'd42, 10'd240));
        op_backlog.push_back(make_op(OP_PEEK,   16'h0000, '0, '0, '0, '0));
        op_backlog.push_back(make_op(OP_SIZE,   16'h0000, '0, '0, '0, '0));
        op_backlog.push_back(make_op(OP_SEARCH, 16'h0000, '0, '0, '0, '0));
        op_backlog.push_back(make_op(OP_SEARCH, 16'hFFFF, '0, '0, '0, '0));
        op_backlog.push_back(make_op(OP_SEARCH, 16'h4321, '0, '0, '0, '0));
        op_backlog.push_back(make_op(OP_DUMP,   16'h0000, '0, '0, '0, '0));
        op_backlog.push_back(make_op(OP_NOP,    16'h0000, '0, '0, '0, '0));
        op_backlog.push_back(make_op(OP_POP,    16'h0000, '0, '0, '0, '0));
        op_backlog.push_back(make_op(OP_POP,    16'h0000, '0, '0, '0, '0));
        op_backlog.push_back(make_op(OP_CLEAR,  16'h0000, '0, '0, '0, '0));
        op_backlog.push_back(make_op(OP_POP,    16'h0000, '0, '0, '0, '0));
        wait_idle();

        // random part, one capacity per phase
        run_phase(4'd8,  40, 1'b1, 1'b0, 1'b0);    // full depth, no idling at all
        run_phase(4'd0,  25, 1'b0, 1'b0, 1'b0);    // zero behaves as one
        run_phase(4'd15, 45, 1'b0, 1'b1, 1'b0);    // above depth, with the long hold-off
        run_phase(4'd8,   9, 1'b0, 1'b0, 1'b1);    // fill to the top
        run_phase(4'd2,  40, 1'b0, 1'b0, 1'b0);    // limit now below the depth held
        run_phase(4'd1,  25, 1'b0, 1'b0, 1'b0);
        run_phase(4'd3,  30, 1'b0, 1'b0, 1'b0);
        run_phase(4'($urandom_range(0, 15)), 40, 1'b0, 1'b0, 1'b0);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
